// ===== hw/rtl/crr_pkg.sv =====
// Shared types and constants for the creep RPM request ramp.
// No dependencies; used by creep_rpm_request_ramp.
`default_nettype none

package crr_pkg;

    // Item kind carried on s_tuser
    typedef enum logic [1:0] {
        MODE_POLL   = 2'd0,
        MODE_FRAME  = 2'd1,
        MODE_STROKE = 2'd2
    } mode_t;

    // Creep state
    typedef enum logic [1:0] {
        PHASE_WAIT = 2'd0,
        PHASE_RAMP = 2'd1,
        PHASE_HOLD = 2'd2
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_CREEP_RPM = 2'd0,
        CFG_RAMP_STEP     = 2'd1,
        CFG_RELEASE_DELAY = 2'd2
    } cfg_index_t;

    localparam int RPM_W  = 14;
    localparam int STEP_W = 8;
    localparam int TICK_W = 16;
    localparam int BYTE_W = 8;

    // Frame byte 5 value that leaves engine start enabled
    localparam logic [BYTE_W-1:0] LOCK_OPEN_CODE = 8'h40;

    localparam logic [RPM_W-1:0]  MIN_CREEP_RESET = 14'd900;
    localparam logic [STEP_W-1:0] RAMP_STEP_RESET = 8'd10;
    localparam logic [TICK_W-1:0] REL_DELAY_RESET = 16'd100;

endpackage

`default_nettype wire

// ===== hw/rtl/creep_rpm_request_ramp.sv =====
// Creep RPM request ramp: top level, input register plus state/result registers.
// Depends on crr_pkg.
`default_nettype none

// Keeps the minimum idle RPM requested on behalf of the transmission. Each input
// transfer is a main-loop poll, a received status frame or an engine stroke event
// (s_tuser). A frame with a nonzero request byte starts a request, either ramping
// up from the measured RPM or straight at min_creep_rpm; frames while the request
// stands refresh the hold stamp; stroke events ramp the request up by ramp_step,
// or, once the request is withdrawn and release_delay ticks have gone by, down
// towards zero. Cranking (polls and frames) clears the request. Every input
// transfer yields exactly one result transfer carrying the state after that item.
// Throughput is one item per cycle unless m_tready holds back the result. An item
// passes through the input register, then the state registers, which also form
// the result register. The state update is a single add/compare pass, so the
// only loop is state -> next state. Configuration writes are always accepted
// (cfg_ready is tied high) and take effect at the next edge.
module creep_rpm_request_ramp (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] cranking, [14:1] measured_rpm, [30:15] now_tick,
    // [38:31] request_byte, [46:39] lock_byte, [47] zero
    input  wire logic [47:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] requested_rpm, [14] start_locked, [16:15] creep_phase, [23:17] zero
    output logic [23:0]      m_tdata
);

    localparam int RPM_W  = crr_pkg::RPM_W;
    localparam int STEP_W = crr_pkg::STEP_W;
    localparam int TICK_W = crr_pkg::TICK_W;
    localparam int BYTE_W = crr_pkg::BYTE_W;

    // configuration registers
    logic [RPM_W-1:0]  min_rpm_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TICK_W-1:0] delay_reg;

    // input register
    logic              in_valid_reg;
    crr_pkg::mode_t    in_mode_reg;
    logic              in_crank_reg;
    logic [RPM_W-1:0]  in_rpm_reg;
    logic [TICK_W-1:0] in_now_reg;
    logic [BYTE_W-1:0] in_req_reg;
    logic [BYTE_W-1:0] in_lock_reg;

    // creep state; also the result register
    logic              out_valid_reg;
    crr_pkg::phase_t   phase_reg, phase_next;
    logic [RPM_W-1:0]  request_reg, request_next;
    logic [TICK_W-1:0] hold_reg, hold_next;
    logic              lock_reg, lock_next;

    logic              advance;
    logic [RPM_W:0]    ramp_sum;
    logic [TICK_W-1:0] since_hold;

    // item moves from input register into state when the result slot is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, phase_reg, lock_reg, request_reg};

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rpm_reg <= crr_pkg::MIN_CREEP_RESET;
            step_reg    <= crr_pkg::RAMP_STEP_RESET;
            delay_reg   <= crr_pkg::REL_DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (crr_pkg::cfg_index_t'(cfg_index))
                crr_pkg::CFG_MIN_CREEP_RPM: min_rpm_reg <= cfg_data[RPM_W-1:0];
                crr_pkg::CFG_RAMP_STEP:     step_reg    <= cfg_data[STEP_W-1:0];
                crr_pkg::CFG_RELEASE_DELAY: delay_reg   <= cfg_data[TICK_W-1:0];
                default: ; // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= crr_pkg::mode_t'(s_tuser);
            in_crank_reg <= s_tdata[0];
            in_rpm_reg   <= s_tdata[14:1];
            in_now_reg   <= s_tdata[30:15];
            in_req_reg   <= s_tdata[38:31];
            in_lock_reg  <= s_tdata[46:39];
        end
    end

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        phase_next   = phase_reg;
        request_next = request_reg;
        hold_next    = hold_reg;
        lock_next    = lock_reg;
        ramp_sum     = {1'b0, request_reg} + {{(RPM_W+1-STEP_W){1'b0}}, step_reg};
        since_hold   = in_now_reg - hold_reg;   // wraps mod 2^16

        // cranking wipes the request before a frame is looked at
        if ((in_mode_reg == crr_pkg::MODE_POLL || in_mode_reg == crr_pkg::MODE_FRAME)
            && in_crank_reg) begin
            request_next = '0;
            phase_next   = crr_pkg::PHASE_WAIT;
        end

        case (in_mode_reg)
            crr_pkg::MODE_FRAME: begin
                lock_next = (in_lock_reg != crr_pkg::LOCK_OPEN_CODE);
                if (phase_next == crr_pkg::PHASE_WAIT) begin
                    if (in_req_reg != '0) begin
                        if (in_rpm_reg < min_rpm_reg) begin
                            request_next = in_rpm_reg;
                            phase_next   = crr_pkg::PHASE_RAMP;
                        end else begin
                            request_next = min_rpm_reg;
                            phase_next   = crr_pkg::PHASE_HOLD;
                        end
                    end
                end else begin
                    // ramp reached target: hold
                    if (phase_next == crr_pkg::PHASE_RAMP && request_next >= min_rpm_reg) begin
                        phase_next = crr_pkg::PHASE_HOLD;
                    end
                    hold_next = in_now_reg;
                    if (in_req_reg == '0) begin
                        phase_next = crr_pkg::PHASE_WAIT;
                    end
                end
            end
            crr_pkg::MODE_STROKE: begin
                if (phase_reg == crr_pkg::PHASE_RAMP) begin
                    if (ramp_sum <= {1'b0, min_rpm_reg}) begin
                        request_next = ramp_sum[RPM_W-1:0];
                    end else begin
                        request_next = min_rpm_reg;
                    end
                end else if (phase_reg == crr_pkg::PHASE_WAIT && since_hold > delay_reg) begin
                    if (request_reg >= {{(RPM_W-STEP_W){1'b0}}, step_reg}) begin
                        request_next = request_reg - {{(RPM_W-STEP_W){1'b0}}, step_reg};
                    end else begin
                        request_next = '0;
                    end
                end
            end
            default: ; // poll (cranking handled above) or unused kind
        endcase
    end

    // ---------------------------------------------------------------------
    // State / result register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= crr_pkg::PHASE_WAIT;
            request_reg   <= '0;
            hold_reg      <= '0;
            lock_reg      <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                request_reg   <= request_next;
                hold_reg      <= hold_next;
                lock_reg      <= lock_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // input stalls only when both stages are full and the result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // a ramping stroke never overshoots the target
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == crr_pkg::MODE_STROKE && phase_reg == crr_pkg::PHASE_RAMP)
        |=> (request_reg <= $past(min_rpm_reg)))
        else $error("ramp overshot minimum creep RPM");

    // cranking poll clears the request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == crr_pkg::MODE_POLL && in_crank_reg)
        |=> (request_reg == '0 && phase_reg == crr_pkg::PHASE_WAIT))
        else $error("cranking did not clear request");

    // lock follows the frame's lock byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == crr_pkg::MODE_FRAME)
        |=> (lock_reg == ($past(in_lock_reg) != crr_pkg::LOCK_OPEN_CODE)))
        else $error("start lock does not match frame");

    // a result goes out only after an item has moved into the state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result valid without an item");

endmodule

`default_nettype wire
